/* rtl/gcp_pkg.sv */
// ----------------------------------------------------------------------------
// gcp_pkg
// Shared types, constants and helpers for the buffer-pool slot manager.
// ----------------------------------------------------------------------------
package gcp_pkg;

	localparam int SLOTS   = 64;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int FREE_W  = $clog2(SLOTS + 1);
	localparam int TAG_W   = 32;
	localparam int CNT_W   = 8;
	localparam int REF_MAX = 255;
	localparam int PIN_MAX = 255;

	// Request modes.
	localparam logic [1:0] MODE_REQ   = 2'd0;
	localparam logic [1:0] MODE_REL   = 2'd1;
	localparam logic [1:0] MODE_FETCH = 2'd2;
	localparam logic [1:0] MODE_NOP   = 2'd3;

	// Result status codes.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_ALL_PIN  = 3'd1;
	localparam logic [2:0] ST_REL_UNP  = 3'd2;
	localparam logic [2:0] ST_MISMATCH = 3'd3;
	localparam logic [2:0] ST_PIN_OVF  = 3'd4;

	typedef struct packed {
		logic [1:0]        mode;
		logic [TAG_W-1:0]  blk_num;
		logic [5:0]        slot;
	} req_t;

	typedef struct packed {
		logic [5:0]        slot_out;
		logic              hit;
		logic              need_read;
		logic              evicted;
		logic [TAG_W-1:0]  evicted_block;
		logic [2:0]        status;
	} rsp_t;

	// One slot entry of the tag/count memory.
	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [CNT_W-1:0]  pin;
		logic [CNT_W-1:0]  rf;
	} word_t;

	// Datapath operations issued by the controller.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_LK,
		OP_FREE,
		OP_EV_RD,
		OP_EV_EX,
		OP_SLOT
	} op_t;

	typedef struct packed {
		op_t   op;
	} cmd_t;

	typedef struct packed {
		logic  fin;
		logic  lk_end;
		logic  has_free;
	} sts_t;

	// Advance a slot pointer with wrap-around.
	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		logic [SLOT_W-1:0] r;
		if (s == SLOT_W'(SLOTS - 1)) begin
			r = '0;
		end else begin
			r = s + 1'b1;
		end
		return r;
	endfunction

endpackage

/* rtl/gcp_ctrl.sv */
// ----------------------------------------------------------------------------
// gcp_ctrl
// Controller: sequences lookup, free fill, eviction sweep and slot operations.
// ----------------------------------------------------------------------------
module gcp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         mode,
	input  gcp_pkg::sts_t      sts,
	output gcp_pkg::cmd_t      cmd,
	output logic               busy
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LK,
		S_FREE,
		S_EV_RD,
		S_EV_EX,
		S_SLOT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;

	// Next state and the operation for this cycle.
	always_comb begin
		state_d = state_q;
		cmd.op  = gcp_pkg::OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op = gcp_pkg::OP_LOAD;
					if (mode == gcp_pkg::MODE_REQ) begin
						state_d = S_LK;
					end else if (mode == gcp_pkg::MODE_REL || mode == gcp_pkg::MODE_FETCH) begin
						state_d = S_SLOT;
					end
				end
			end
			S_LK: begin
				cmd.op = gcp_pkg::OP_LK;
				if (sts.fin) begin
					state_d = S_IDLE;
				end else if (sts.lk_end) begin
					state_d = sts.has_free ? S_FREE : S_EV_RD;
				end
			end
			S_FREE: begin
				cmd.op = gcp_pkg::OP_FREE;
				if (sts.fin) begin
					state_d = S_IDLE;
				end
			end
			S_EV_RD: begin
				cmd.op  = gcp_pkg::OP_EV_RD;
				state_d = S_EV_EX;
			end
			S_EV_EX: begin
				cmd.op  = gcp_pkg::OP_EV_EX;
				state_d = sts.fin ? S_IDLE : S_EV_RD;
			end
			S_SLOT: begin
				cmd.op  = gcp_pkg::OP_SLOT;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
		end
	end

	assign busy = busy_q;

endmodule

/* rtl/gcp_dp.sv */
// ----------------------------------------------------------------------------
// gcp_dp
// Datapath: slot memory, valid and loaded bits, hand, free count and results.
// ----------------------------------------------------------------------------
module gcp_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  gcp_pkg::req_t      req,
	input  gcp_pkg::cmd_t      cmd,
	output gcp_pkg::sts_t      sts,
	output gcp_pkg::rsp_t      rsp,
	output logic               done
);

	localparam int LK_W = gcp_pkg::SLOT_W + 1;

	gcp_pkg::word_t                mem [gcp_pkg::SLOTS];
	gcp_pkg::word_t                rd_q;
	logic [gcp_pkg::SLOTS-1:0]     vld_q;
	logic [gcp_pkg::SLOTS-1:0]     ld_q;
	gcp_pkg::req_t                 req_q;
	logic [LK_W-1:0]               cnt_q;
	logic [gcp_pkg::SLOT_W-1:0]    idx_s1;
	logic                          lk_v_s1;
	logic                          anyfree_q;
	logic [gcp_pkg::SLOT_W-1:0]    scan_q;
	logic [gcp_pkg::SLOT_W-1:0]    hand_q;
	logic [gcp_pkg::FREE_W-1:0]    free_q;
	gcp_pkg::rsp_t                 rsp_q;
	logic                          done_q;

	logic                          rd_en;
	logic [gcp_pkg::SLOT_W-1:0]    rd_addr;
	logic                          wr_en;
	logic [gcp_pkg::SLOT_W-1:0]    wr_addr;
	gcp_pkg::word_t                wr_data;
	gcp_pkg::word_t                fill_word;
	gcp_pkg::rsp_t                 res_d;
	logic [gcp_pkg::SLOT_W-1:0]    cur_idx;
	logic                          cur_vld;
	logic [gcp_pkg::CNT_W-1:0]     pin_eff;
	logic [gcp_pkg::CNT_W-1:0]     ref_eff;
	logic                          match;
	logic                          lk_last;
	logic                          anyfree_now;
	logic                          fin;
	logic                          fetch_ok;

	// Operation decode: memory access, result and completion.
	always_comb begin
		cur_idx     = (cmd.op == gcp_pkg::OP_LK) ? idx_s1 : scan_q;
		cur_vld     = vld_q[cur_idx];
		pin_eff     = cur_vld ? rd_q.pin : '0;
		ref_eff     = cur_vld ? rd_q.rf : '0;
		match       = lk_v_s1 && cur_vld && (rd_q.tag == req_q.blk_num);
		lk_last     = lk_v_s1 && (idx_s1 == gcp_pkg::SLOT_W'(gcp_pkg::SLOTS - 1));
		anyfree_now = anyfree_q || (lk_v_s1 && pin_eff == '0);
		fill_word   = '{tag: req_q.blk_num, pin: gcp_pkg::CNT_W'(1), rf: gcp_pkg::CNT_W'(1)};
		fetch_ok    = cur_vld && (rd_q.tag == req_q.blk_num);

		rd_en   = 1'b0;
		rd_addr = scan_q;
		wr_en   = 1'b0;
		wr_addr = scan_q;
		wr_data = fill_word;
		res_d   = '0;
		fin     = 1'b0;
		sts     = '0;
		sts.has_free = (free_q != '0);

		unique case (cmd.op)
			gcp_pkg::OP_LOAD: begin
				rd_en   = 1'b1;
				rd_addr = req.slot[gcp_pkg::SLOT_W-1:0];
			end
			gcp_pkg::OP_LK: begin
				rd_en   = (cnt_q < LK_W'(gcp_pkg::SLOTS));
				rd_addr = cnt_q[gcp_pkg::SLOT_W-1:0];
				if (match) begin
					fin            = 1'b1;
					res_d.slot_out = 6'(idx_s1);
					res_d.hit      = 1'b1;
					if (pin_eff == gcp_pkg::CNT_W'(gcp_pkg::PIN_MAX)) begin
						res_d.status = gcp_pkg::ST_PIN_OVF;
					end else begin
						wr_en       = 1'b1;
						wr_addr     = idx_s1;
						wr_data.tag = rd_q.tag;
						wr_data.pin = pin_eff + 1'b1;
						wr_data.rf  = (ref_eff < gcp_pkg::CNT_W'(gcp_pkg::REF_MAX))
							? ref_eff + 1'b1 : ref_eff;
					end
				end else if (lk_last) begin
					sts.lk_end = 1'b1;
					if (free_q == '0 && !anyfree_now) begin
						fin          = 1'b1;
						res_d.status = gcp_pkg::ST_ALL_PIN;
					end
				end
			end
			gcp_pkg::OP_FREE: begin
				if (!vld_q[scan_q]) begin
					fin            = 1'b1;
					wr_en          = 1'b1;
					res_d.slot_out = 6'(scan_q);
				end
			end
			gcp_pkg::OP_EV_RD: begin
				rd_en = 1'b1;
			end
			gcp_pkg::OP_EV_EX: begin
				if (pin_eff == '0) begin
					if (!cur_vld) begin
						fin            = 1'b1;
						wr_en          = 1'b1;
						res_d.slot_out = 6'(scan_q);
					end else if (ref_eff <= gcp_pkg::CNT_W'(1)) begin
						fin                 = 1'b1;
						wr_en               = 1'b1;
						res_d.slot_out      = 6'(scan_q);
						res_d.evicted       = 1'b1;
						res_d.evicted_block = rd_q.tag;
					end else begin
						wr_en      = 1'b1;
						wr_data    = rd_q;
						wr_data.rf = ref_eff - 1'b1;
					end
				end
			end
			gcp_pkg::OP_SLOT: begin
				fin            = 1'b1;
				res_d.slot_out = 6'(scan_q);
				if (req_q.mode == gcp_pkg::MODE_REL) begin
					if (pin_eff == '0) begin
						res_d.status = gcp_pkg::ST_REL_UNP;
					end else begin
						wr_en       = 1'b1;
						wr_data     = rd_q;
						wr_data.pin = pin_eff - 1'b1;
					end
				end else if (!fetch_ok) begin
					res_d.status = gcp_pkg::ST_MISMATCH;
				end else begin
					res_d.need_read = !ld_q[scan_q];
				end
			end
			default: begin
			end
		endcase
		sts.fin = fin;
	end

	// Slot memory with registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Control state of the datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			ld_q    <= '0;
			hand_q  <= '0;
			free_q  <= gcp_pkg::FREE_W'(gcp_pkg::SLOTS);
			lk_v_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= fin;
			unique case (cmd.op)
				gcp_pkg::OP_LOAD: begin
					lk_v_s1 <= 1'b0;
				end
				gcp_pkg::OP_LK: begin
					lk_v_s1 <= rd_en;
				end
				gcp_pkg::OP_FREE: begin
					if (fin) begin
						vld_q[scan_q] <= 1'b1;
						ld_q[scan_q]  <= 1'b0;
						hand_q        <= gcp_pkg::next_slot(scan_q);
						free_q        <= free_q - 1'b1;
					end
				end
				gcp_pkg::OP_EV_EX: begin
					if (fin) begin
						vld_q[scan_q] <= 1'b1;
						ld_q[scan_q]  <= 1'b0;
						hand_q        <= gcp_pkg::next_slot(scan_q);
					end
				end
				gcp_pkg::OP_SLOT: begin
					if (req_q.mode == gcp_pkg::MODE_FETCH && fetch_ok) begin
						ld_q[scan_q] <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers: captured request, scan pointers and result.
	always_ff @(posedge clk) begin
		if (fin) begin
			rsp_q <= res_d;
		end
		unique case (cmd.op)
			gcp_pkg::OP_LOAD: begin
				req_q     <= req;
				cnt_q     <= '0;
				anyfree_q <= 1'b0;
				scan_q    <= (req.mode == gcp_pkg::MODE_REQ)
					? hand_q : req.slot[gcp_pkg::SLOT_W-1:0];
			end
			gcp_pkg::OP_LK: begin
				if (rd_en) begin
					cnt_q <= cnt_q + 1'b1;
				end
				idx_s1 <= rd_addr;
				if (lk_v_s1 && pin_eff == '0) begin
					anyfree_q <= 1'b1;
				end
			end
			gcp_pkg::OP_FREE: begin
				if (!fin) begin
					scan_q <= gcp_pkg::next_slot(scan_q);
				end
			end
			gcp_pkg::OP_EV_EX: begin
				if (!fin) begin
					scan_q <= gcp_pkg::next_slot(scan_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp  = rsp_q;
	assign done = done_q;

endmodule

/* rtl/gclock_pinned_buffer_pool.sv */
// ----------------------------------------------------------------------------
// gclock_pinned_buffer_pool
// Buffer-pool slot manager with pin counts and generalized-clock replacement.
// ----------------------------------------------------------------------------
// Usage: drive req and raise start; the beat is taken at a rising edge where
// start is high and busy is low. Busy then stays high until the item is done;
// mode 3 is taken with busy left low and gives no result.
// Each request, release or fetch gives one result beat on rsp, marked by done
// for exactly one cycle. The receiver cannot stall, so rsp must be taken in
// the cycle done is high.
// Sequence: release and fetch read the slot at accept, then form the result in
// the slot state. A request scans the 64 tags one per cycle through the slot
// memory read port to a hit or an all-pinned answer. A miss with free slots
// then walks slots from the hand. An eviction sweeps slots with a read, then a
// count update of each slot swept, and a sweep may lap the pool several times
// while reference counts drain.
// Busy is low while done is high, so the next item can be taken at the edge
// that takes the result.
// Reset clears valid and loaded bits and the hand, sets the free count to the
// slot count; invalid slots read zero counts, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module gclock_pinned_buffer_pool (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  gcp_pkg::req_t      req,
	output logic               busy,
	output gcp_pkg::rsp_t      rsp,
	output logic               done
);

	gcp_pkg::cmd_t cmd;
	gcp_pkg::sts_t sts;

	// Sequencer.
	gcp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (req.mode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Slot state and result formation.
	gcp_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp),
		.done   (done)
	);

	// A result beat is never followed by another in the next cycle.
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back result beats");

	// An accepted item other than mode 3 always raises busy.
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.mode != gcp_pkg::MODE_NOP) |=> busy)
		else $error("busy not raised after accept");

	// A hit never reports an eviction.
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.hit) |-> !rsp.evicted)
		else $error("hit with eviction");

	// An all-pinned answer reports slot zero and no hit.
	a_allpin_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == gcp_pkg::ST_ALL_PIN) |-> (rsp.slot_out == 6'd0 && !rsp.hit))
		else $error("all-pinned result with slot");

endmodule
